@@ hw/rtl/sqsw_pkg.sv @@
// Package for the square channel with frequency sweep.
// Holds opcodes, register indexes, widths and the shared types.
// No dependencies; imported by every module of the block.
`default_nettype none

package sqsw_pkg;

  // Length counter limit and derived widths
  localparam int LENGTH_MAX = 64;
  localparam int LEN_W = $clog2(LENGTH_MAX + 1);
  localparam logic [LEN_W-1:0] LEN_MAX_V = LEN_W'(LENGTH_MAX);
  localparam logic [7:0] LEN_MASK = 8'(LENGTH_MAX - 1);

  // Signed width of the advance accumulator: -255 .. 8192
  localparam int T_W = 15;

  localparam int IN_W = 24;
  localparam int OUT_W = 40;

  // Item kinds
  localparam logic [1:0] OP_WRITE = 2'd0;
  localparam logic [1:0] OP_SWEEP = 2'd1;
  localparam logic [1:0] OP_ADVANCE = 2'd2;

  // Channel register indexes
  localparam logic [2:0] REG_SWEEP = 3'd0;
  localparam logic [2:0] REG_DUTY_LEN = 3'd1;
  localparam logic [2:0] REG_ENVELOPE = 3'd2;
  localparam logic [2:0] REG_FREQ_LO = 3'd3;
  localparam logic [2:0] REG_FREQ_HI = 3'd4;

  // Request to the shared add/subtract unit: a +/- (b >> shift)
  typedef struct packed {
    logic signed [T_W-1:0] a;
    logic [13:0]           b;
    logic [2:0]            shift;
    logic                  sub;
  } alu_req_t;

  // Result beat, first field in the highest bits
  typedef struct packed {
    logic [13:0] period_timer;
    logic [6:0]  length_count;
    logic [3:0]  envelope_volume;
    logic [10:0] frequency;
    logic [2:0]  duty_position;
    logic        channel_active;
  } result_t;

endpackage

`default_nettype wire

@@ hw/rtl/sqsw_alu.sv @@
// Shared shift and add/subtract unit of the square channel.
// Depends on sqsw_pkg for the request type and widths.
`default_nettype none

module sqsw_alu
  import sqsw_pkg::*;
(
  input  alu_req_t              req,
  output logic signed [T_W-1:0] res
);

  logic [13:0]           shifted;
  logic signed [T_W-1:0] operand;

  assign shifted = req.b >> req.shift;
  assign operand = $signed(T_W'(shifted));
  assign res = req.sub ? (req.a - operand) : (req.a + operand);

endmodule

`default_nettype wire

@@ hw/rtl/sqsw_obuf.sv @@
// Output register stage for result beats of the square channel.
// Depends on sqsw_pkg for the result type.
`default_nettype none

module sqsw_obuf
  import sqsw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             load,
  input  result_t          data,
  output logic             ready,
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata
);

  result_t hold;

  // Take a new beat when empty or when the current one drains this cycle
  assign ready = !m_tvalid || m_tready;
  assign m_tdata = hold;

  always_ff @(posedge clk) begin
    if (rst) begin
      m_tvalid <= 1'b0;
    end else if (load) begin
      m_tvalid <= 1'b1;
    end else if (m_tready) begin
      m_tvalid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      hold <= data;
    end
  end

endmodule

`default_nettype wire

@@ hw/rtl/square_channel_with_sweep_core.sv @@
// Square-wave sound channel with frequency sweep, top level.
// Depends on sqsw_pkg, sqsw_alu (shared adder) and sqsw_obuf (result register).
//
// Usage:
//   Input beats arrive on s_tvalid/s_tready with the item kind in s_tuser
//   (0 register write, 1 sweep clock, 2 timer advance, 3 no operation) and
//   reg_index, write_data, cycles and seq_step_odd packed in s_tdata.
//   Every input beat yields exactly one result beat on m_tvalid/m_tready
//   carrying the channel state after the item.
//   Path: a write or a no-op passes S_EXEC and S_DONE on its way from
//   acceptance to the result register, a trigger with sweep shift adds
//   S_TRIGCHK, a sweep clock up to S_SWEEP1 and S_SWEEP2, and a cycle
//   advance S_ADV, which handles N period wraps (at most 64 with the
//   shortest period of 4). The wraps are counted one per cycle through the
//   single shared add/subtract unit, which also computes every sweep frequency step.
//   One item is processed at a time: s_tready is high only while the
//   sequencer is idle. A finished result waits in the output register, so
//   the next item is accepted while the receiver stalls; the sequencer
//   holds its finished item only if the output register is still full.
//   Reset (rst, synchronous) clears all channel state except t_acc to zero
//   and empties the output register.
`default_nettype none

module square_channel_with_sweep_core
  import sqsw_pkg::*;
(
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,  // reg_index[2:0], write_data[10:3], cycles[18:11],
                                     // seq_step_odd[19], zero fill[23:20]
  input  logic [1:0]       s_tuser,  // op[1:0]
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata   // channel_active[0], duty_position[3:1],
                                     // frequency[14:4], envelope_volume[18:15],
                                     // length_count[25:19], period_timer[39:26]
);

  // Sequencer states
  localparam logic [2:0] S_IDLE    = 3'd0;
  localparam logic [2:0] S_EXEC    = 3'd1;
  localparam logic [2:0] S_TRIGCHK = 3'd2;
  localparam logic [2:0] S_SWEEP1  = 3'd3;
  localparam logic [2:0] S_SWEEP2  = 3'd4;
  localparam logic [2:0] S_ADV     = 3'd5;
  localparam logic [2:0] S_DONE    = 3'd6;

  logic [2:0] state, state_next;

  // Captured item
  logic [1:0] op_q;
  logic [2:0] idx_q;
  logic [7:0] data_q;
  logic [7:0] cyc_q;
  logic       odd_q;

  // Channel state
  logic [7:0]       sweep_reg, sweep_reg_next;
  logic [7:0]       envelope_reg, envelope_reg_next;
  logic [7:0]       freq_low_reg, freq_low_reg_next;
  logic [6:0]       freq_high_reg, freq_high_reg_next;
  logic [10:0]      shadow_frequency, shadow_frequency_next;
  logic [3:0]       sweep_countdown, sweep_countdown_next;
  logic             sweep_enabled, sweep_enabled_next;
  logic             negate_used, negate_used_next;
  logic             active_flag, active_flag_next;
  logic [LEN_W-1:0] length_counter, length_counter_next;
  logic             length_enabled, length_enabled_next;
  logic [13:0]      period_counter, period_counter_next;
  logic [2:0]       duty_step, duty_step_next;
  logic [3:0]       volume, volume_next;
  logic signed [T_W-1:0] t_acc, t_acc_next;

  // Derived values
  logic [10:0] cur_freq;
  logic [10:0] trig_freq;
  logic [13:0] period_len;
  logic [13:0] trig_period;
  logic [2:0]  pace;
  logic [2:0]  shift;
  logic        neg;
  logic [3:0]  pace_reload;
  logic [3:0]  cd_dec;
  logic        dac_on;

  alu_req_t              alu_req;
  logic signed [T_W-1:0] alu_res;
  logic                  f_over;

  result_t result;
  logic    obuf_ready;
  logic    obuf_load;

  assign cur_freq    = {freq_high_reg[2:0], freq_low_reg};
  assign trig_freq   = {data_q[2:0], freq_low_reg};
  assign period_len  = {12'(12'd2048 - {1'b0, cur_freq}), 2'b00};
  assign trig_period = {12'(12'd2048 - {1'b0, trig_freq}), 2'b00};
  assign pace        = sweep_reg[6:4];
  assign shift       = sweep_reg[2:0];
  assign neg         = sweep_reg[3];
  assign pace_reload = (pace != 3'd0) ? {1'b0, pace} : 4'd8;
  assign cd_dec      = (sweep_countdown != 4'd0) ? (sweep_countdown - 4'd1) : sweep_countdown;
  assign dac_on      = (envelope_reg[7:3] != 5'd0);

  assign s_tready = (state == S_IDLE);

  // Operand select for the shared unit: sweep step by default,
  // timer minus cycles at advance start, timer plus period on a wrap.
  always_comb begin
    alu_req.a     = $signed(T_W'(shadow_frequency));
    alu_req.b     = 14'(shadow_frequency);
    alu_req.shift = shift;
    alu_req.sub   = neg;
    if (state == S_EXEC) begin
      alu_req.a     = $signed(T_W'(period_counter));
      alu_req.b     = 14'(cyc_q);
      alu_req.shift = 3'd0;
      alu_req.sub   = 1'b1;
    end else if (state == S_ADV) begin
      alu_req.a     = t_acc;
      alu_req.b     = period_len;
      alu_req.shift = 3'd0;
      alu_req.sub   = 1'b0;
    end
  end

  sqsw_alu u_alu (
    .req (alu_req),
    .res (alu_res)
  );

  // Sweep result past eleven bits
  assign f_over = (alu_res[T_W-1:11] != '0);

  always_comb begin
    state_next            = state;
    sweep_reg_next        = sweep_reg;
    envelope_reg_next     = envelope_reg;
    freq_low_reg_next     = freq_low_reg;
    freq_high_reg_next    = freq_high_reg;
    shadow_frequency_next = shadow_frequency;
    sweep_countdown_next  = sweep_countdown;
    sweep_enabled_next    = sweep_enabled;
    negate_used_next      = negate_used;
    active_flag_next      = active_flag;
    length_counter_next   = length_counter;
    length_enabled_next   = length_enabled;
    period_counter_next   = period_counter;
    duty_step_next        = duty_step;
    volume_next           = volume;
    t_acc_next            = t_acc;
    obuf_load             = 1'b0;

    case (state)
      S_IDLE: begin
        if (s_tvalid) begin
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        state_next = S_DONE;
        case (op_q)
          OP_WRITE: begin
            case (idx_q)
              REG_SWEEP: begin
                sweep_reg_next = data_q;
                // Clearing negate after it was used kills the channel
                if (negate_used && !data_q[3]) begin
                  active_flag_next = 1'b0;
                  negate_used_next = 1'b0;
                end
              end
              REG_DUTY_LEN: begin
                length_counter_next = LEN_W'(data_q & LEN_MASK);
              end
              REG_ENVELOPE: begin
                envelope_reg_next = data_q;
                if (data_q[7:3] == 5'd0) begin
                  active_flag_next = 1'b0;
                end
              end
              REG_FREQ_LO: begin
                freq_low_reg_next = data_q;
              end
              REG_FREQ_HI: begin
                length_enabled_next = data_q[6];
                // Extra length clock when length turns on in the first half
                if (!length_enabled && data_q[6] && !odd_q &&
                    (length_counter < LEN_MAX_V)) begin
                  length_counter_next = length_counter + LEN_W'(1);
                  if ((length_counter + LEN_W'(1)) >= LEN_MAX_V) begin
                    active_flag_next = 1'b0;
                  end
                end
                freq_high_reg_next = data_q[6:0];
                if (data_q[7]) begin
                  if (length_counter_next >= LEN_MAX_V) begin
                    length_counter_next = (data_q[6] && !odd_q) ? LEN_W'(1) : LEN_W'(0);
                  end
                  if (dac_on) begin
                    active_flag_next      = 1'b1;
                    shadow_frequency_next = trig_freq;
                    sweep_countdown_next  = pace_reload;
                    sweep_enabled_next    = (pace != 3'd0) || (shift != 3'd0);
                    negate_used_next      = 1'b0;
                    if (shift != 3'd0) begin
                      state_next = S_TRIGCHK;
                    end
                  end
                  period_counter_next = trig_period;
                  volume_next         = envelope_reg[7:4];
                end
              end
              default: begin
              end
            endcase
          end

          OP_SWEEP: begin
            if (sweep_enabled) begin
              sweep_countdown_next = cd_dec;
              if (cd_dec == 4'd0) begin
                sweep_countdown_next = pace_reload;
              end
              if ((cd_dec == 4'd0) && (pace != 3'd0)) begin
                state_next = S_SWEEP1;
              end else if (negate_used && !neg) begin
                active_flag_next = 1'b0;
                negate_used_next = 1'b0;
              end
            end
          end

          OP_ADVANCE: begin
            t_acc_next = alu_res;
            state_next = S_ADV;
          end

          default: begin
          end
        endcase
      end

      S_TRIGCHK: begin
        if (neg) begin
          negate_used_next = 1'b1;
        end
        if (f_over) begin
          active_flag_next = 1'b0;
        end
        state_next = S_DONE;
      end

      S_SWEEP1: begin
        state_next = S_DONE;
        if (neg) begin
          negate_used_next = 1'b1;
        end
        if (f_over) begin
          active_flag_next = 1'b0;
        end else if (shift != 3'd0) begin
          shadow_frequency_next = alu_res[10:0];
          freq_low_reg_next     = alu_res[7:0];
          freq_high_reg_next    = {freq_high_reg[6:3], alu_res[10:8]};
          state_next            = S_SWEEP2;
        end
        if ((state_next == S_DONE) && negate_used && !neg) begin
          active_flag_next = 1'b0;
          negate_used_next = 1'b0;
        end
      end

      S_SWEEP2: begin
        if (neg) begin
          negate_used_next = 1'b1;
        end
        if (f_over) begin
          active_flag_next = 1'b0;
        end
        if (negate_used && !neg) begin
          active_flag_next = 1'b0;
          negate_used_next = 1'b0;
        end
        state_next = S_DONE;
      end

      S_ADV: begin
        // One period wrap per cycle until the timer is positive
        if (t_acc[T_W-1] || (t_acc == '0)) begin
          duty_step_next = duty_step + 3'd1;
          t_acc_next     = alu_res;
        end else begin
          period_counter_next = t_acc[13:0];
          state_next          = S_DONE;
        end
      end

      S_DONE: begin
        if (obuf_ready) begin
          obuf_load  = 1'b1;
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state            <= S_IDLE;
      sweep_reg        <= '0;
      envelope_reg     <= '0;
      freq_low_reg     <= '0;
      freq_high_reg    <= '0;
      shadow_frequency <= '0;
      sweep_countdown  <= '0;
      sweep_enabled    <= 1'b0;
      negate_used      <= 1'b0;
      active_flag      <= 1'b0;
      length_counter   <= '0;
      length_enabled   <= 1'b0;
      period_counter   <= '0;
      duty_step        <= '0;
      volume           <= '0;
    end else begin
      state            <= state_next;
      sweep_reg        <= sweep_reg_next;
      envelope_reg     <= envelope_reg_next;
      freq_low_reg     <= freq_low_reg_next;
      freq_high_reg    <= freq_high_reg_next;
      shadow_frequency <= shadow_frequency_next;
      sweep_countdown  <= sweep_countdown_next;
      sweep_enabled    <= sweep_enabled_next;
      negate_used      <= negate_used_next;
      active_flag      <= active_flag_next;
      length_counter   <= length_counter_next;
      length_enabled   <= length_enabled_next;
      period_counter   <= period_counter_next;
      duty_step        <= duty_step_next;
      volume           <= volume_next;
    end
  end

  // Item capture and advance accumulator: payload only
  always_ff @(posedge clk) begin
    if (s_tvalid && s_tready) begin
      op_q   <= s_tuser;
      idx_q  <= s_tdata[2:0];
      data_q <= s_tdata[10:3];
      cyc_q  <= s_tdata[18:11];
      odd_q  <= s_tdata[19];
    end
    t_acc <= t_acc_next;
  end

  always_comb begin
    result.channel_active  = active_flag;
    result.duty_position   = duty_step;
    result.frequency       = cur_freq;
    result.envelope_volume = volume;
    result.length_count    = 7'(length_counter);
    result.period_timer    = period_counter;
  end

  sqsw_obuf u_obuf (
    .clk      (clk),
    .rst      (rst),
    .load     (obuf_load),
    .data     (result),
    .ready    (obuf_ready),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata)
  );

endmodule

`default_nettype wire

@@ hw/rtl/sqsw_chk.sv @@
// Port-level checker for square_channel_with_sweep_core, bound to the top.
// Depends on sqsw_pkg for the port widths.
`default_nettype none

module sqsw_chk
  import sqsw_pkg::*;
(
  input wire             clk,
  input wire             rst,
  input wire             s_tvalid,
  input wire             s_tready,
  input wire             m_tvalid,
  input wire             m_tready,
  input wire [OUT_W-1:0] m_tdata
);

  // One item at a time: no beat accepted right after another
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    (s_tvalid && s_tready) |=> !s_tready)
    else $error("input accepted while an item is in work");

  // A result never shows up the cycle right after acceptance
  a_min_latency: assert property (@(posedge clk) disable iff (rst)
    $rose(m_tvalid) |-> !$past(s_tvalid && s_tready))
    else $error("result beat appeared too early");

  // Reset empties the result register
  a_reset_empty: assert property (@(posedge clk)
    rst |=> !m_tvalid)
    else $error("result beat valid after reset");

  // Stalled result beat holds
  a_hold: assert property (@(posedge clk) disable iff (rst)
    (m_tvalid && !m_tready) |=> (m_tvalid && $stable(m_tdata)))
    else $error("stalled result beat changed");

endmodule

bind square_channel_with_sweep_core sqsw_chk u_sqsw_chk (
  .clk      (clk),
  .rst      (rst),
  .s_tvalid (s_tvalid),
  .s_tready (s_tready),
  .m_tvalid (m_tvalid),
  .m_tready (m_tready),
  .m_tdata  (m_tdata)
);

`default_nettype wire
